>>> hdl/opd_pkg.sv
// Shared types for the octree patch deframer: parser phases and the node record.
package opd_pkg;

  typedef enum logic [3:0] {
    PH_VERSION = 4'd0,
    PH_X       = 4'd1,
    PH_Y       = 4'd2,
    PH_Z       = 4'd3,
    PH_TCOUNT  = 4'd4,
    PH_TNUM    = 4'd5,
    PH_NCOUNT  = 4'd6,
    PH_NODE    = 4'd7
  } phase_t;

  typedef struct packed {
    logic signed [31:0] version;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [7:0]         tree_count;
    logic [7:0]         tree_number;
    logic [15:0]        nodes_in_tree;
    logic [15:0]        node_position;
    logic [7:0]         material;
    logic [7:0]         distance_byte;
    logic [15:0]        first_child;
    logic               stream_error;
  } rec_t;

endpackage

>>> hdl/opd_in_if.sv
// Byte channel into the deframer: one stream byte and its end-of-stream mark.
interface opd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> hdl/opd_out_if.sv
// Record channel out of the deframer: one node record or one error item.
interface opd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] version;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic [7:0]         tree_count;
  logic [7:0]         tree_number;
  logic [15:0]        nodes_in_tree;
  logic [15:0]        node_position;
  logic [7:0]         material;
  logic [7:0]         distance_byte;
  logic [15:0]        first_child;
  logic               stream_error;

  modport source (
    output valid, output version, output pos_x, output pos_y, output pos_z,
    output tree_count, output tree_number, output nodes_in_tree,
    output node_position, output material, output distance_byte,
    output first_child, output stream_error, input ready
  );
  modport sink (
    input valid, input version, input pos_x, input pos_y, input pos_z,
    input tree_count, input tree_number, input nodes_in_tree,
    input node_position, input material, input distance_byte,
    input first_child, input stream_error, output ready
  );
endinterface

>>> hdl/opd_parse.sv
// Byte-serial parser state and the record built by the byte that completes a node.
module opd_parse import opd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       res_valid,
  output rec_t       res
);

  phase_t      phase, phase_next;
  logic [1:0]  bif, bif_next;
  logic [31:0] version_reg, version_reg_next;
  logic [15:0] x_reg, x_reg_next;
  logic [15:0] y_reg, y_reg_next;
  logic [15:0] z_reg, z_reg_next;
  logic [7:0]  tree_count_reg, tree_count_reg_next;
  logic [7:0]  trees_left, trees_left_next;
  logic [7:0]  tree_number_reg, tree_number_reg_next;
  logic [15:0] node_count_reg, node_count_reg_next;
  logic [15:0] node_index_reg, node_index_reg_next;
  logic [23:0] node_bytes, node_bytes_next;
  logic [7:0]  trees_left_dec;
  logic        node_done;
  logic        early_end;

  assign trees_left_dec = trees_left - 8'd1;

  // Next state
  always_comb begin
    phase_next           = phase;
    bif_next             = bif;
    version_reg_next     = version_reg;
    x_reg_next           = x_reg;
    y_reg_next           = y_reg;
    z_reg_next           = z_reg;
    tree_count_reg_next  = tree_count_reg;
    trees_left_next      = trees_left;
    tree_number_reg_next = tree_number_reg;
    node_count_reg_next  = node_count_reg;
    node_index_reg_next  = node_index_reg;
    node_bytes_next      = node_bytes;
    node_done            = 1'b0;
    early_end            = 1'b0;

    case (phase)
      PH_VERSION: begin
        version_reg_next[{bif, 3'b000} +: 8] = data_byte;
        if (bif == 2'd3) begin
          bif_next   = 2'd0;
          phase_next = PH_X;
        end else begin
          bif_next = bif + 2'd1;
        end
      end
      PH_X, PH_Y, PH_Z: begin
        if (phase == PH_X) begin
          if (bif[0]) x_reg_next[15:8] = data_byte;
          else        x_reg_next[7:0]  = data_byte;
        end else if (phase == PH_Y) begin
          if (bif[0]) y_reg_next[15:8] = data_byte;
          else        y_reg_next[7:0]  = data_byte;
        end else begin
          if (bif[0]) z_reg_next[15:8] = data_byte;
          else        z_reg_next[7:0]  = data_byte;
        end
        if (bif[0]) begin
          bif_next   = 2'd0;
          phase_next = (phase == PH_X) ? PH_Y : ((phase == PH_Y) ? PH_Z : PH_TCOUNT);
        end else begin
          bif_next = 2'd1;
        end
      end
      PH_TCOUNT: begin
        tree_count_reg_next = data_byte;
        trees_left_next     = data_byte;
        bif_next            = 2'd0;
        phase_next          = (data_byte == 8'd0) ? PH_X : PH_TNUM;
      end
      PH_TNUM: begin
        tree_number_reg_next = data_byte;
        bif_next             = 2'd0;
        phase_next           = PH_NCOUNT;
      end
      PH_NCOUNT: begin
        if (bif[0]) begin
          node_count_reg_next[15:8] = data_byte;
          node_index_reg_next       = 16'd0;
          bif_next                  = 2'd0;
          if ({data_byte, node_count_reg[7:0]} == 16'd0) begin
            // empty octree: close it now
            trees_left_next = trees_left_dec;
            phase_next      = (trees_left_dec == 8'd0) ? PH_X : PH_TNUM;
          end else begin
            phase_next = PH_NODE;
          end
        end else begin
          node_count_reg_next[7:0] = data_byte;
          bif_next                 = 2'd1;
        end
      end
      PH_NODE: begin
        case (bif)
          2'd0: begin
            node_bytes_next[7:0] = data_byte;
            bif_next             = 2'd1;
          end
          2'd1: begin
            node_bytes_next[15:8] = data_byte;
            bif_next              = 2'd2;
          end
          2'd2: begin
            node_bytes_next[23:16] = data_byte;
            bif_next               = 2'd3;
          end
          default: begin
            node_done           = 1'b1;
            bif_next            = 2'd0;
            node_index_reg_next = node_index_reg + 16'd1;
            if (node_index_reg_next == node_count_reg) begin
              trees_left_next = trees_left_dec;
              phase_next      = (trees_left_dec == 8'd0) ? PH_X : PH_TNUM;
            end
          end
        endcase
      end
      default: begin
        phase_next = PH_VERSION;
        bif_next   = 2'd0;
      end
    endcase

    // end of stream: anything but a batch boundary is an early end
    if (last_byte) begin
      early_end  = !(phase_next == PH_X && bif_next == 2'd0);
      phase_next = PH_VERSION;
      bif_next   = 2'd0;
    end
  end

  // Result
  always_comb begin
    res_valid = accept && (node_done || early_end);
    res       = '0;
    if (early_end) begin
      res.stream_error = 1'b1;
    end else begin
      res.version       = version_reg;
      res.pos_x         = x_reg;
      res.pos_y         = y_reg;
      res.pos_z         = z_reg;
      res.tree_count    = tree_count_reg;
      res.tree_number   = tree_number_reg;
      res.nodes_in_tree = node_count_reg;
      res.node_position = node_index_reg;
      res.material      = node_bytes[7:0];
      res.distance_byte = node_bytes[15:8];
      res.first_child   = {data_byte, node_bytes[23:16]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_VERSION;
      bif             <= 2'd0;
      version_reg     <= '0;
      x_reg           <= '0;
      y_reg           <= '0;
      z_reg           <= '0;
      tree_count_reg  <= '0;
      trees_left      <= '0;
      tree_number_reg <= '0;
      node_count_reg  <= '0;
      node_index_reg  <= '0;
      node_bytes      <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      bif             <= bif_next;
      version_reg     <= version_reg_next;
      x_reg           <= x_reg_next;
      y_reg           <= y_reg_next;
      z_reg           <= z_reg_next;
      tree_count_reg  <= tree_count_reg_next;
      trees_left      <= trees_left_next;
      tree_number_reg <= tree_number_reg_next;
      node_count_reg  <= node_count_reg_next;
      node_index_reg  <= node_index_reg_next;
      node_bytes      <= node_bytes_next;
    end
  end

endmodule

>>> hdl/octree_patch_deframer_top.sv
// Octree patch deframer: byte stream in, one record per completed node out.
//
// in_ch carries one stream byte per item, with last_byte set on the final byte.
// out_ch carries one record per node whose fourth byte arrives, tagged with its
// version, batch position, octree count, octree number, node count and index.
// If the byte marked last leaves a structure unfinished, one error item with
// stream_error set and all other fields zero goes out instead.
//
// Throughput: one byte per cycle while ready is high. The parser updates its
// state and builds the record in the cycle a byte is accepted; the record is
// then registered in the output register, or in the skid register on a stall.
// Stall: a one-entry skid register behind the output register catches a record
// produced while the receiver holds off, so bytes keep flowing; ready drops
// only while the skid entry is full, and returns once the receiver takes one.
// Reset (rst, synchronous): the parser returns to the version field and both
// output entries empty. After the last byte of a stream the next byte opens
// a new stream.
module octree_patch_deframer_top import opd_pkg::*; (
  input logic      clk,
  input logic      rst,
  opd_in_if.sink   in_ch,
  opd_out_if.source out_ch
);

  logic accept;
  logic res_valid;
  rec_t res;
  logic out_valid;
  rec_t out_rec;
  logic skid_valid;
  rec_t skid_rec;
  logic out_free;

  // take bytes whenever the skid entry has room
  assign in_ch.ready = !skid_valid;
  assign accept      = in_ch.valid && in_ch.ready;

  opd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register may load when empty or being drained this cycle
  assign out_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      // skid entry first; while it is full no new byte was accepted
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      // receiver holding off: park the new record
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_rec <= skid_valid ? skid_rec : res;
    end
    if (!out_free && res_valid) begin
      skid_rec <= res;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.version       = out_rec.version;
  assign out_ch.pos_x         = out_rec.pos_x;
  assign out_ch.pos_y         = out_rec.pos_y;
  assign out_ch.pos_z         = out_rec.pos_z;
  assign out_ch.tree_count    = out_rec.tree_count;
  assign out_ch.tree_number   = out_rec.tree_number;
  assign out_ch.nodes_in_tree = out_rec.nodes_in_tree;
  assign out_ch.node_position = out_rec.node_position;
  assign out_ch.material      = out_rec.material;
  assign out_ch.distance_byte = out_rec.distance_byte;
  assign out_ch.first_child   = out_rec.first_child;
  assign out_ch.stream_error  = out_rec.stream_error;

`ifndef NO_ASSERTIONS
  // the skid entry is only ever filled behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full while output register empty");

  // skid loads only when the receiver stalled a pending record
  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ch.ready))
    else $error("skid entry loaded without a stall");

  // an error item carries no record contents
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_rec.stream_error) |->
      (out_rec.version == 32'sd0 && out_rec.tree_count == 8'd0 &&
       out_rec.node_position == 16'd0 && out_rec.first_child == 16'd0))
    else $error("error item with nonzero record fields");
`endif

endmodule
